/* rtl/i2cdw_pkg.sv */
// Package: shared types and constants for the display write I2C master.
package i2cdw_pkg;

  // Bus sequencer modes
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_START = 2'd1,
    MODE_SEND  = 2'd2,
    MODE_STOP  = 2'd3
  } bus_mode_t;

  // Byte slots within one transfer
  localparam logic [1:0] SLOT_ADDR = 2'd0;
  localparam logic [1:0] SLOT_CTRL = 2'd1;
  localparam logic [1:0] SLOT_BYTE = 2'd2;

  // Control bytes and reset address
  localparam logic [7:0] CTRL_CMD   = 8'h00;
  localparam logic [7:0] CTRL_DATA  = 8'h40;
  localparam logic [7:0] ADDR_RESET = 8'h78;

  // Step counts within one byte: 8 bits of 3 steps, then the ack clock
  localparam logic [4:0] BIT_STEPS = 5'd24;
  localparam logic [4:0] ACK_LAST  = 5'd26;

  // Request kinds
  localparam logic REQ_TICK     = 1'b0;
  localparam logic REQ_TRANSFER = 1'b1;

  // Input beat
  typedef struct packed {
    logic       req_type;
    logic [7:0] byte_value;
    logic       is_data;
    logic       keep_open;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic accepted;
  } out_beat_t;

endpackage

/* rtl/i2c_display_write_master.sv */
// Top level: write-only I2C master for a display controller, one pin step per beat.
//
// Usage:
//   in_*  : one beat per bus tick (req_type 0) or transfer request (req_type 1)
//           carrying byte_value, is_data and keep_open.
//   out_* : one result beat per input beat with the SCL/SDA levels after that
//           beat, a busy flag and whether a request was taken.
//   cfg_* : cfg_we writes cfg_wdata into the address byte (reset 0x78).
// A request from a free bus gives start, address byte, control byte (0x00 or
// 0x40) and the data byte; with keep_open the bus is held with SCL low and the
// next request sends its byte alone. Requests while busy are refused.
// The result of each accepted beat is registered in the output register. One
// beat per cycle is taken while the receiver does not stall, with the
// combinational sequencer update feeding the output register.
// Reset (synchronous, rst_n low): bus idle with both lines released, output
// register empty. When the receiver stalls, the output register holds its beat
// and in_ready drops until the beat is taken; the sequencer does not advance.
module i2c_display_write_master
  import i2cdw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  // Sequencer state
  bus_mode_t  mode_r, mode_nxt;
  logic [4:0] step_r, step_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] pend_byte_r, pend_byte_nxt;
  logic       pend_data_r, pend_data_nxt;
  logic       hold_r, hold_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       acc_nxt;
  logic [7:0] addr_r;

  // Output register
  logic      out_valid_r;
  out_beat_t out_data_r;
  logic      in_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Compute next sequencer state for the current beat
  always_comb begin
    mode_nxt      = mode_r;
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    slot_nxt      = slot_r;
    shift_nxt     = shift_r;
    pend_byte_nxt = pend_byte_r;
    pend_data_nxt = pend_data_r;
    hold_nxt      = hold_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    acc_nxt       = 1'b0;

    if (in_data.req_type == REQ_TRANSFER) begin
      // Take a request only from an idle or held bus
      if (mode_r == MODE_IDLE) begin
        acc_nxt   = 1'b1;
        step_nxt  = '0;
        phase_nxt = '0;
        if (hold_r) begin
          mode_nxt      = MODE_SEND;
          slot_nxt      = SLOT_BYTE;
          shift_nxt     = in_data.byte_value;
          pend_byte_nxt = in_data.byte_value;
        end else begin
          mode_nxt      = MODE_START;
          pend_byte_nxt = in_data.byte_value;
          pend_data_nxt = in_data.is_data;
          slot_nxt      = SLOT_ADDR;
        end
        hold_nxt = in_data.keep_open;
      end
    end else begin
      unique case (mode_r)
        MODE_START: begin
          if (step_r == 5'd0) begin
            sda_nxt  = 1'b0;
            step_nxt = 5'd1;
          end else begin
            scl_nxt   = 1'b0;
            mode_nxt  = MODE_SEND;
            slot_nxt  = SLOT_ADDR;
            shift_nxt = addr_r;
            step_nxt  = '0;
            phase_nxt = '0;
          end
        end
        MODE_SEND: begin
          if (step_r < BIT_STEPS) begin
            // Set data, raise clock, lower clock and shift
            case (phase_r)
              2'd0: begin
                sda_nxt   = shift_r[7];
                phase_nxt = 2'd1;
              end
              2'd1: begin
                scl_nxt   = 1'b1;
                phase_nxt = 2'd2;
              end
              default: begin
                scl_nxt   = 1'b0;
                shift_nxt = {shift_r[6:0], 1'b0};
                phase_nxt = 2'd0;
              end
            endcase
            step_nxt = step_r + 5'd1;
          end else if (step_r == BIT_STEPS) begin
            sda_nxt  = 1'b1;
            step_nxt = step_r + 5'd1;
          end else if (step_r < ACK_LAST) begin
            scl_nxt  = 1'b1;
            step_nxt = step_r + 5'd1;
          end else begin
            // End of ack clock: move to next byte or finish
            scl_nxt   = 1'b0;
            step_nxt  = '0;
            phase_nxt = '0;
            if (slot_r == SLOT_ADDR) begin
              slot_nxt  = SLOT_CTRL;
              shift_nxt = pend_data_r ? CTRL_DATA : CTRL_CMD;
            end else if (slot_r == SLOT_CTRL) begin
              slot_nxt  = SLOT_BYTE;
              shift_nxt = pend_byte_r;
            end else begin
              mode_nxt = hold_r ? MODE_IDLE : MODE_STOP;
            end
          end
        end
        MODE_STOP: begin
          if (step_r == 5'd0) begin
            sda_nxt  = 1'b0;
            step_nxt = 5'd1;
          end else if (step_r == 5'd1) begin
            scl_nxt  = 1'b1;
            step_nxt = 5'd2;
          end else begin
            sda_nxt   = 1'b1;
            mode_nxt  = MODE_IDLE;
            hold_nxt  = 1'b0;
            step_nxt  = '0;
            phase_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
    end else if (cfg_we) begin
      addr_r <= cfg_wdata;
    end
  end

  // Advance sequencer on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      step_r      <= '0;
      phase_r     <= '0;
      slot_r      <= SLOT_ADDR;
      shift_r     <= '0;
      pend_byte_r <= '0;
      pend_data_r <= 1'b0;
      hold_r      <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
    end else if (in_fire) begin
      mode_r      <= mode_nxt;
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      slot_r      <= slot_nxt;
      shift_r     <= shift_nxt;
      pend_byte_r <= pend_byte_nxt;
      pend_data_r <= pend_data_nxt;
      hold_r      <= hold_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
    end
  end

  // Load result beat, drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.scl_level <= scl_nxt;
      out_data_r.sda_level <= sda_nxt;
      out_data_r.busy_res  <= (mode_nxt != MODE_IDLE);
      out_data_r.accepted  <= acc_nxt;
    end
  end

  // A taken request always leaves the bus busy
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.accepted |-> out_data_r.busy_res)
    else $error("accepted request reported with idle bus");

  // A free, unheld bus has both lines released
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) && !hold_r |-> scl_r && sda_r)
    else $error("idle bus not released");

  // Step count stays within one byte plus ack while sending
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_SEND) |-> (step_r <= ACK_LAST) && (phase_r != 2'd3))
    else $error("send step count out of range");

  // Bit phase tracks the step count at the start of every byte
  a_phase_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_SEND) && (step_r == 5'd0) |-> (phase_r == 2'd0))
    else $error("bit phase out of step at byte start");

endmodule
